[hdl/bcd_rtc_to_epoch_seconds_macros.svh]
// Assertion macros for the BCD clock to epoch converter.
// Each macro takes a label, the clock, the active-low reset, a condition and a
// consequence. The first checks the consequence in the same cycle, the second
// in the cycle after.
`ifndef BCD_RTC_TO_EPOCH_SECONDS_MACROS_SVH
`define BCD_RTC_TO_EPOCH_SECONDS_MACROS_SVH

`ifndef SYNTH

`define BCDEP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

`define BCDEP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define BCDEP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons)

`define BCDEP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

[hdl/bcdep_pkg.sv]
`timescale 1ns / 1ps

package bcdep_pkg;

    // Calendar constants.
    localparam int EPOCH_YEAR    = 1970;
    localparam int BASE_YEAR     = 2000;
    localparam int CENTURY       = 100;
    localparam int DAYS_PER_YEAR = 365;
    localparam int HOURS_PER_DAY = 24;
    localparam int MIN_PER_HOUR  = 60;
    localparam int SEC_PER_MIN   = 60;

    // Years from the epoch to the base year of the two-digit year.
    localparam int YEAR_OFFSET = BASE_YEAR - EPOCH_YEAR;
    // Leap days before year 2000+yy, counted from the epoch, are (yy + LEAP_BIAS) / 4.
    // Inside 1970..2099 every fourth year is a leap year, 2000 included.
    localparam int LEAP_BIAS = BASE_YEAR - EPOCH_YEAR + 1;

    localparam int SEC_MAX   = 59;
    localparam int MIN_MAX   = 59;
    localparam int HOUR_MAX  = 23;
    localparam int DAY_MIN   = 1;
    localparam int DAY_MAX   = 31;
    localparam int MONTH_MIN = 1;
    localparam int MONTH_MAX = 12;
    localparam int FEBRUARY  = 2;

    localparam logic [15:0] DAYS_LIMIT = 16'd47482;
    localparam logic [31:0] EPOCH_LIMIT = 32'd4102444799;

    typedef struct packed {
        logic [7:0] sec_bcd;
        logic [7:0] min_bcd;
        logic [7:0] hour_bcd;
        logic [7:0] day_bcd;
        logic [7:0] month_bcd;
        logic [7:0] year_bcd;
    } rtc_item_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        time_valid;
    } epoch_item_t;

    // Decoded fields after the first stage.
    typedef struct packed {
        logic       ok;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] yy;
    } dec_t;

    // Day count plus the time of day after the second stage.
    typedef struct packed {
        logic        ok;
        logic [15:0] days;
        logic [4:0]  hour;
        logic [5:0]  min;
        logic [5:0]  sec;
    } days_t;

    function automatic logic bcd_digits_ok(input logic [7:0] b);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

    // Tens times ten plus units; tens*10 is formed as tens*8 + tens*2.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]};
        return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[hdl/bcdep_decode.sv]
`timescale 1ns / 1ps

// First stage: BCD to binary and the range checks.
module bcdep_decode
    import bcdep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  rtc_item_t src_item,
    output logic      dst_valid,
    input  logic      dst_ready,
    output dec_t      dst_item
);

    logic       valid_reg;
    logic       valid_next;
    dec_t       item_reg;
    dec_t       item_next;
    logic [7:0] sec_b;
    logic [7:0] min_b;
    logic [7:0] hour_b;
    logic [7:0] day_b;
    logic [7:0] month_b;
    logic [7:0] year_b;
    logic       digits_ok;
    logic       range_ok;

    always_comb
    begin
        sec_b   = bcd_to_bin(src_item.sec_bcd);
        min_b   = bcd_to_bin(src_item.min_bcd);
        hour_b  = bcd_to_bin(src_item.hour_bcd);
        day_b   = bcd_to_bin(src_item.day_bcd);
        month_b = bcd_to_bin(src_item.month_bcd);
        year_b  = bcd_to_bin(src_item.year_bcd);

        digits_ok = bcd_digits_ok(src_item.sec_bcd) && bcd_digits_ok(src_item.min_bcd)
                 && bcd_digits_ok(src_item.hour_bcd) && bcd_digits_ok(src_item.day_bcd)
                 && bcd_digits_ok(src_item.month_bcd) && bcd_digits_ok(src_item.year_bcd);

        range_ok = (sec_b <= 8'(SEC_MAX)) && (min_b <= 8'(MIN_MAX))
                && (hour_b <= 8'(HOUR_MAX))
                && (day_b >= 8'(DAY_MIN)) && (day_b <= 8'(DAY_MAX))
                && (month_b >= 8'(MONTH_MIN)) && (month_b <= 8'(MONTH_MAX))
                && (year_b < 8'(CENTURY));

        item_next.ok    = digits_ok && range_ok;
        item_next.sec   = sec_b[5:0];
        item_next.min   = min_b[5:0];
        item_next.hour  = hour_b[4:0];
        item_next.day   = day_b[4:0];
        item_next.month = month_b[3:0];
        item_next.yy    = year_b[6:0];
    end

    assign src_ready  = !valid_reg || dst_ready;
    assign valid_next = src_ready ? src_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_item  = item_reg;

endmodule

[hdl/bcdep_days.sv]
`timescale 1ns / 1ps

// Second stage: day count since the epoch from year, month and day.
module bcdep_days
    import bcdep_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  src_valid,
    output logic  src_ready,
    input  dec_t  src_item,
    output logic  dst_valid,
    input  logic  dst_ready,
    output days_t dst_item
);

    logic        valid_reg;
    logic        valid_next;
    days_t       item_reg;
    days_t       item_next;
    logic [7:0]  years;
    logic [15:0] year_days;
    logic [7:0]  leap_sum;
    logic [5:0]  leap_days;
    logic        leap_year;
    logic        extra_day;

    always_comb
    begin
        years     = {1'b0, src_item.yy} + 8'(YEAR_OFFSET);
        year_days = 16'(years) * 16'(DAYS_PER_YEAR);
        leap_sum  = {1'b0, src_item.yy} + 8'(LEAP_BIAS);
        leap_days = leap_sum[7:2];
        leap_year = (src_item.yy[1:0] == 2'b00);
        extra_day = leap_year && (src_item.month > 4'(FEBRUARY));

        item_next.ok   = src_item.ok;
        item_next.days = year_days + 16'(leap_days)
                       + 16'(days_before_month(src_item.month))
                       + 16'(extra_day) + 16'(src_item.day) - 16'(DAY_MIN);
        item_next.hour = src_item.hour;
        item_next.min  = src_item.min;
        item_next.sec  = src_item.sec;
    end

    assign src_ready  = !valid_reg || dst_ready;
    assign valid_next = src_ready ? src_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_item  = item_reg;

endmodule

[hdl/bcdep_time.sv]
`timescale 1ns / 1ps

// Stages three to five: days to hours, hours to minutes, minutes to seconds.
// Each stage is one constant multiply and an add; the last register is the
// output register of the block.
module bcdep_time
    import bcdep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_ready,
    input  days_t       src_item,
    output logic        dst_valid,
    input  logic        dst_ready,
    output epoch_item_t dst_item
);

    // Hours stage.
    logic        h_valid_reg;
    logic        h_valid_next;
    logic        h_ready;
    logic        h_ok_reg;
    logic [20:0] h_total_reg;
    logic [5:0]  h_min_reg;
    logic [5:0]  h_sec_reg;

    // Minutes stage.
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        m_ready;
    logic        m_ok_reg;
    logic [26:0] m_total_reg;
    logic [5:0]  m_sec_reg;

    // Seconds stage, the output register.
    logic        s_valid_reg;
    logic        s_valid_next;
    logic        s_ready;
    epoch_item_t s_item_reg;
    logic [31:0] s_total;

    assign s_ready = !s_valid_reg || dst_ready;
    assign m_ready = !m_valid_reg || s_ready;
    assign h_ready = !h_valid_reg || m_ready;

    assign h_valid_next = h_ready ? src_valid   : h_valid_reg;
    assign m_valid_next = m_ready ? h_valid_reg : m_valid_reg;
    assign s_valid_next = s_ready ? m_valid_reg : s_valid_reg;

    assign s_total = 32'(m_total_reg) * 32'(SEC_PER_MIN) + 32'(m_sec_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg <= h_valid_next;
            m_valid_reg <= m_valid_next;
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_ready && src_valid)
        begin
            h_ok_reg    <= src_item.ok;
            h_total_reg <= 21'(src_item.days) * 21'(HOURS_PER_DAY) + 21'(src_item.hour);
            h_min_reg   <= src_item.min;
            h_sec_reg   <= src_item.sec;
        end
        if (m_ready && h_valid_reg)
        begin
            m_ok_reg    <= h_ok_reg;
            m_total_reg <= 27'(h_total_reg) * 27'(MIN_PER_HOUR) + 27'(h_min_reg);
            m_sec_reg   <= h_sec_reg;
        end
        if (s_ready && m_valid_reg)
        begin
            s_item_reg.time_valid    <= m_ok_reg;
            s_item_reg.epoch_seconds <= m_ok_reg ? s_total : 32'd0;
        end
    end

    assign src_ready = h_ready;
    assign dst_valid = s_valid_reg;
    assign dst_item  = s_item_reg;

endmodule

[hdl/bcd_rtc_to_epoch_seconds.sv]
// BCD real-time clock date to epoch seconds converter.
// An rtc item carries six BCD bytes as read from a clock chip: seconds,
// minutes, hours (24-hour), day, month and the year within the century,
// taken as 2000 to 2099. An epoch item carries the seconds since
// 1970-01-01 00:00:00 and time_valid. Any nibble above 9 or any field out of
// its calendar range gives time_valid 0 with epoch_seconds 0. A day of 01 to
// 31 is taken in every month; a day past the end of its month runs on into
// the next month.
// Both channels use valid and ready; an item moves on an edge where both are
// high. The block is a five-stage pipeline: decode and range check, day
// count, then one multiply-add stage each for hours, minutes and seconds.
// Epoch_valid rises once an accepted item has passed the decode, day count,
// hours, minutes and seconds registers in that order; one item is taken
// every cycle while epoch_ready stays high.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling up; rtc_ready drops only once every stage
// holds an item. Reset empties all stages; no item is lost or repeated.
`timescale 1ns / 1ps
`include "bcd_rtc_to_epoch_seconds_macros.svh"

module bcd_rtc_to_epoch_seconds
    import bcdep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rtc_valid,
    output logic        rtc_ready,
    input  rtc_item_t   rtc_item,
    output logic        epoch_valid,
    input  logic        epoch_ready,
    output epoch_item_t epoch_item
);

    // Stage handshakes between the submodules.
    logic  dec_valid;
    logic  dec_ready;
    dec_t  dec_item;
    logic  days_valid;
    logic  days_ready;
    days_t days_item;

    bcdep_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (rtc_valid),
        .src_ready (rtc_ready),
        .src_item  (rtc_item),
        .dst_valid (dec_valid),
        .dst_ready (dec_ready),
        .dst_item  (dec_item)
    );

    bcdep_days u_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (dec_valid),
        .src_ready (dec_ready),
        .src_item  (dec_item),
        .dst_valid (days_valid),
        .dst_ready (days_ready),
        .dst_item  (days_item)
    );

    bcdep_time u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (days_valid),
        .src_ready (days_ready),
        .src_item  (days_item),
        .dst_valid (epoch_valid),
        .dst_ready (epoch_ready),
        .dst_item  (epoch_item)
    );

    // An invalid timestamp must leave the block as zero seconds.
    `BCDEP_ASSERT_SAME(a_invalid_is_zero, clk, rst_n,
        epoch_valid && !epoch_item.time_valid, epoch_item.epoch_seconds == 32'd0)

    // A valid result never passes the end of 2099.
    `BCDEP_ASSERT_SAME(a_epoch_in_range, clk, rst_n,
        epoch_valid && epoch_item.time_valid, epoch_item.epoch_seconds <= EPOCH_LIMIT)

    // The day count of a checked date stays below the end of 2099.
    `BCDEP_ASSERT_SAME(a_days_in_range, clk, rst_n,
        days_valid && days_item.ok, days_item.days < DAYS_LIMIT)

    // A receiver that is ready frees every stage, so the input must be ready.
    `BCDEP_ASSERT_SAME(a_ready_chain, clk, rst_n, epoch_ready, rtc_ready)

endmodule
